// ----- src/vbs_pkg.sv -----
// vbs_pkg: sizes, register codes, states and helper functions of the
// per-pixel background subtractor; no dependencies
package vbs_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int NUM_SAMPLES = 20;

    localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_SIZE = NUM_SAMPLES * PLANE_SIZE;

    localparam int ADDR_W  = $clog2(STORE_SIZE);
    localparam int OFF_W   = $clog2(PLANE_SIZE);
    localparam int X_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W  = $clog2(NUM_SAMPLES);
    localparam int COUNT_W = $clog2(NUM_SAMPLES + 1);

    // fixed field widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 7;
    localparam int GATE_W  = 8;
    localparam int RAND_W  = 16;
    localparam int DIR_W   = 3;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 3;
    localparam int MINM_W  = 5;
    localparam int SUBS_W  = 4;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_MATCH_RADIUS   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_MATCHES    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SUBSAMPLE_LOG2 = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BG_VALUE       = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_FG_VALUE       = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH    = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_MATCH_RADIUS   = 8'd20;
    localparam logic [MINM_W-1:0] RST_MIN_MATCHES    = 5'd2;
    localparam logic [SUBS_W-1:0] RST_SUBSAMPLE_LOG2 = 4'd4;
    localparam logic [CFG_W-1:0]  RST_BG_VALUE       = 8'd0;
    localparam logic [CFG_W-1:0]  RST_FG_VALUE       = 8'd255;
    localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH    = 8'd128;
    localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT   = 8'd128;

    // request codes
    localparam logic REQ_INIT   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // neighbour directions, clockwise from up-left
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP         = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd4;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd6;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_INIT_WR,
        ST_RD,
        ST_DRAIN,
        ST_DECIDE,
        ST_SSLOT,
        ST_SWR,
        ST_NSLOT,
        ST_NWR,
        ST_DONE
    } state_t;

    // slot = (word * NUM_SAMPLES) >> 16, kept below NUM_SAMPLES
    function automatic logic [SLOT_W-1:0] pick_slot(input logic [RAND_W-1:0] word);
        logic [31:0] prod;
        logic [31:0] s;
        prod = 32'(word) * 32'(NUM_SAMPLES);
        s = prod >> RAND_W;
        if (s > 32'(NUM_SAMPLES - 1))
            s = 32'(NUM_SAMPLES - 1);
        return SLOT_W'(s);
    endfunction

    // open when the low subsample_log2 bits of the gate byte are zero
    function automatic logic gate_open(input logic [GATE_W-1:0] gate,
                                       input logic [SUBS_W-1:0] log2);
        logic [GATE_W-1:0] mask;
        if (log2 >= SUBS_W'(GATE_W))
            mask = '1;
        else
            mask = GATE_W'((9'd1 << log2) - 9'd1);
        return (gate & mask) == '0;
    endfunction

endpackage

// ----- src/vbs_ram.sv -----
// vbs_ram: generic single-port ram with registered read
// no dependencies
module vbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/vibe_background_subtractor.sv -----
// vibe_background_subtractor: per-pixel sample model, classification and
// random model update; uses vbs_pkg and one vbs_ram for the sample store
//
// Usage
//   Input channel (in_valid / in_stall) carries one request word per pixel:
//   req_type 0 writes the pixel into every sample slot of its position,
//   req_type 1 compares the pixel with the stored samples, reports
//   background or foreground and, for background, may refresh one own slot
//   and one slot of a neighbour. Output channel (out_valid / out_stall)
//   returns one word per request: mask_value and is_foreground.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must do so only while idle, as the block does not enforce it.
// Flow
//   All sample traffic goes through the single store port, one access per
//   cycle. Init writes the pixel into each slot in turn; update reads the
//   20 samples, drains the read pipeline, decides, and for each of up to two
//   write-backs picks a slot and writes it. in_stall is high from accept
//   until the result sits in the output register.
// Reset
//   Registers return to their defaults, both channels go empty. The store
//   is not cleared: a position must be initialised before it is updated.
// Stall
//   A stalled result holds in the output register; the next word may be
//   accepted and processed meanwhile, and waits to finish until it drains.
module vibe_background_subtractor (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [vbs_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [vbs_pkg::CFG_W-1:0]     cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [vbs_pkg::PIX_W-1:0]     pixel,
    input  logic [vbs_pkg::COORD_W-1:0]   pixel_x,
    input  logic [vbs_pkg::COORD_W-1:0]   pixel_y,
    input  logic [vbs_pkg::GATE_W-1:0]    self_gate_rand,
    input  logic [vbs_pkg::RAND_W-1:0]    self_slot_rand,
    input  logic [vbs_pkg::GATE_W-1:0]    nbr_gate_rand,
    input  logic [vbs_pkg::DIR_W-1:0]     nbr_dir,
    input  logic [vbs_pkg::RAND_W-1:0]    nbr_slot_rand,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vbs_pkg::PIX_W-1:0]     mask_value,
    output logic                          is_foreground
);

    import vbs_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]  match_radius_reg;
    logic [MINM_W-1:0] min_matches_reg;
    logic [SUBS_W-1:0] subsample_log2_reg;
    logic [CFG_W-1:0]  bg_value_reg;
    logic [CFG_W-1:0]  fg_value_reg;
    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;

    // control
    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               fg_reg, fg_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic               req_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [X_W-1:0]     x_reg;
    logic [Y_W-1:0]     y_reg;
    logic [GATE_W-1:0]  sgate_reg;
    logic [RAND_W-1:0]  sslot_rand_reg;
    logic [GATE_W-1:0]  ngate_reg;
    logic [DIR_W-1:0]   dir_reg;
    logic [RAND_W-1:0]  nslot_rand_reg;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [PIX_W-1:0]   mask_reg;
    logic               is_fg_reg;

    logic [WDIM_W-1:0]  w_dim;
    logic [HDIM_W-1:0]  h_dim;
    logic [X_W-1:0]     x_clamp;
    logic [Y_W-1:0]     y_clamp;
    logic [X_W-1:0]     nx;
    logic [Y_W-1:0]     ny;
    logic               in_take;
    logic               out_load;
    logic               sample_hit;
    logic               self_open;
    logic               nbr_open;
    logic               below_min;
    logic [ADDR_W-1:0]  slot_addr;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIX_W-1:0]   ram_rdata;

    vbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pix_reg),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // saturated frame size and pixel position
    always_comb
    begin
        int wi;
        int hi;
        int xi;
        int yi;
        wi = int'(frame_width_reg);
        hi = int'(frame_height_reg);
        if (wi < 1)
            wi = 1;
        if (wi > MAX_WIDTH)
            wi = MAX_WIDTH;
        if (hi < 1)
            hi = 1;
        if (hi > MAX_HEIGHT)
            hi = MAX_HEIGHT;
        xi = int'(pixel_x);
        yi = int'(pixel_y);
        if (xi >= wi)
            xi = wi - 1;
        if (yi >= hi)
            yi = hi - 1;
        w_dim   = WDIM_W'(wi);
        h_dim   = HDIM_W'(hi);
        x_clamp = X_W'(xi);
        y_clamp = Y_W'(yi);
    end

    // neighbour position, clamped to the frame
    always_comb
    begin
        int nxi;
        int nyi;
        nxi = int'(x_reg);
        nyi = int'(y_reg);
        if (dir_reg inside {DIR_UP_LEFT, DIR_LEFT, DIR_DOWN_LEFT})
            nxi = nxi - 1;
        if (dir_reg inside {DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT})
            nxi = nxi + 1;
        if (dir_reg inside {DIR_UP_LEFT, DIR_UP, DIR_UP_RIGHT})
            nyi = nyi - 1;
        if (dir_reg inside {DIR_DOWN_LEFT, DIR_DOWN, DIR_DOWN_RIGHT})
            nyi = nyi + 1;
        if (nxi < 0)
            nxi = 0;
        if (nxi > int'(w_dim) - 1)
            nxi = int'(w_dim) - 1;
        if (nyi < 0)
            nyi = 0;
        if (nyi > int'(h_dim) - 1)
            nyi = int'(h_dim) - 1;
        nx = X_W'(nxi);
        ny = Y_W'(nyi);
    end

    assign sample_hit = ((ram_rdata > pix_reg) ? (ram_rdata - pix_reg)
                                               : (pix_reg - ram_rdata)) < match_radius_reg;
    assign self_open  = gate_open(sgate_reg, subsample_log2_reg);
    assign nbr_open   = gate_open(ngate_reg, subsample_log2_reg);
    assign below_min  = 32'(count_reg) < 32'(min_matches_reg);
    assign slot_addr  = ADDR_W'(slot_reg) * ADDR_W'(PLANE_SIZE) + ADDR_W'(off_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = (req_reg == REQ_INIT) ? ST_INIT_WR : ST_RD;
            end
            ST_INIT_WR:
            begin
                if (cnt_reg == SLOT_W'(NUM_SAMPLES - 1))
                    state_next = ST_DONE;
            end
            ST_RD:
            begin
                if (cnt_reg == SLOT_W'(NUM_SAMPLES - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (below_min)
                    state_next = ST_DONE;
                else if (self_open)
                    state_next = ST_SSLOT;
                else if (nbr_open)
                    state_next = ST_NSLOT;
                else
                    state_next = ST_DONE;
            end
            ST_SSLOT:
            begin
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                state_next = nbr_open ? ST_NSLOT : ST_DONE;
            end
            ST_NSLOT:
            begin
                state_next = ST_NWR;
            end
            ST_NWR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // store port and datapath
    always_comb
    begin
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        addr_next     = addr_reg;
        off_next      = off_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        count_next    = count_reg;
        fg_next       = fg_reg;
        rd_valid_next = (state_reg == ST_RD);
        if (rd_valid_reg && sample_hit)
            count_next = count_reg + COUNT_W'(1);
        case (state_reg)
            ST_PREP:
            begin
                off_next   = OFF_W'(y_reg) * OFF_W'(w_dim) + OFF_W'(x_reg);
                addr_next  = ADDR_W'(OFF_W'(y_reg) * OFF_W'(w_dim) + OFF_W'(x_reg));
                cnt_next   = '0;
                count_next = '0;
                fg_next    = 1'b0;
            end
            ST_INIT_WR, ST_RD:
            begin
                ram_we    = (state_reg == ST_INIT_WR);
                addr_next = addr_reg + ADDR_W'(PLANE_SIZE);
                cnt_next  = cnt_reg + SLOT_W'(1);
            end
            ST_DECIDE:
            begin
                fg_next = below_min;
            end
            ST_SSLOT:
            begin
                slot_next = pick_slot(sslot_rand_reg);
            end
            ST_NSLOT:
            begin
                slot_next = pick_slot(nslot_rand_reg);
                off_next  = OFF_W'(ny) * OFF_W'(w_dim) + OFF_W'(nx);
            end
            ST_SWR, ST_NWR:
            begin
                ram_we   = 1'b1;
                ram_addr = slot_addr;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            count_reg          <= '0;
            rd_valid_reg       <= 1'b0;
            fg_reg             <= 1'b0;
            out_valid_reg      <= 1'b0;
            match_radius_reg   <= RST_MATCH_RADIUS;
            min_matches_reg    <= RST_MIN_MATCHES;
            subsample_log2_reg <= RST_SUBSAMPLE_LOG2;
            bg_value_reg       <= RST_BG_VALUE;
            fg_value_reg       <= RST_FG_VALUE;
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            fg_reg        <= fg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MATCH_RADIUS:   match_radius_reg   <= cfg_data;
                    CFG_MIN_MATCHES:    min_matches_reg    <= cfg_data[MINM_W-1:0];
                    CFG_SUBSAMPLE_LOG2: subsample_log2_reg <= cfg_data[SUBS_W-1:0];
                    CFG_BG_VALUE:       bg_value_reg       <= cfg_data;
                    CFG_FG_VALUE:       fg_value_reg       <= cfg_data;
                    CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                    CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg        <= req_type;
            pix_reg        <= pixel;
            x_reg          <= x_clamp;
            y_reg          <= y_clamp;
            sgate_reg      <= self_gate_rand;
            sslot_rand_reg <= self_slot_rand;
            ngate_reg      <= nbr_gate_rand;
            dir_reg        <= nbr_dir;
            nslot_rand_reg <= nbr_slot_rand;
        end
        off_reg  <= off_next;
        addr_reg <= addr_next;
        slot_reg <= slot_next;
        if (out_load)
        begin
            mask_reg  <= fg_reg ? fg_value_reg : bg_value_reg;
            is_fg_reg <= fg_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mask_value    = mask_reg;
    assign is_foreground = is_fg_reg;

    // an accepted word always starts with the address preparation cycle
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_PREP)
        else $error("accepted word did not enter preparation");

    // a new result only appears out of the finishing state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside finishing state");

    // the match counter cannot pass the number of samples
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(NUM_SAMPLES))
        else $error("match count out of range");

    // no store writes while samples are being read back
    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD || state_reg == ST_DRAIN |-> !ram_we)
        else $error("store write during read phase");

endmodule
